// ----- rtl/psu_pkg.sv -----
`timescale 1ns / 1ps
package psu_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int BUF_WIDTH   = 39;
   localparam int CODE_WIDTH  = 32;
   localparam int FRAC_WIDTH  = 33;
   localparam int BITS_WIDTH  = 6;
   localparam int WSEL_WIDTH  = 3;
   localparam int ADDR_WIDTH  = 3;
   localparam int DATA_WIDTH  = 32;

   localparam logic [WSEL_WIDTH-1:0] W_1  = 3'd0;
   localparam logic [WSEL_WIDTH-1:0] W_2  = 3'd1;
   localparam logic [WSEL_WIDTH-1:0] W_4  = 3'd2;
   localparam logic [WSEL_WIDTH-1:0] W_8  = 3'd3;
   localparam logic [WSEL_WIDTH-1:0] W_12 = 3'd4;
   localparam logic [WSEL_WIDTH-1:0] W_16 = 3'd5;
   localparam logic [WSEL_WIDTH-1:0] W_24 = 3'd6;
   localparam logic [WSEL_WIDTH-1:0] W_32 = 3'd7;

   localparam logic REG_WIDTH_SELECT = 1'b0;
   localparam logic REG_SAMPLE_COUNT = 1'b1;

   localparam logic [WSEL_WIDTH-1:0]  WSEL_RESET  = W_8;
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(1);

   typedef struct packed {
      logic                   clear;
      logic [WSEL_WIDTH-1:0]  wsel;
      logic [COUNT_WIDTH-1:0] target;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_type;

   function automatic logic [BITS_WIDTH-1:0] sample_bits(input logic [WSEL_WIDTH-1:0] wsel);
      logic [BITS_WIDTH-1:0] b;
      unique case (wsel)
         W_1:     b = 6'd1;
         W_2:     b = 6'd2;
         W_4:     b = 6'd4;
         W_8:     b = 6'd8;
         W_12:    b = 6'd12;
         W_16:    b = 6'd16;
         W_24:    b = 6'd24;
         default: b = 6'd32;
      endcase
      return b;
   endfunction

   // code / (2^b - 1) in Q1.32, rounded; the constant multiply is a replication
   function automatic logic [FRAC_WIDTH-1:0] norm_fraction(
      input logic [CODE_WIDTH-1:0] code,
      input logic [WSEL_WIDTH-1:0] wsel
   );
      logic [31:0] x;
      logic [36:0] y12;
      logic [48:0] y24;
      logic [FRAC_WIDTH-1:0] f;
      x   = '0;
      y12 = {1'b0, {3{code[11:0]}}} + 37'd8;
      y24 = {1'b0, {2{code[23:0]}}} + 49'h8000;
      unique case (wsel)
         W_1:     x = {32{code[0]}};
         W_2:     x = {16{code[1:0]}};
         W_4:     x = {8{code[3:0]}};
         W_8:     x = {4{code[7:0]}};
         W_16:    x = {2{code[15:0]}};
         default: x = code;
      endcase
      f = {1'b0, x} + {32'd0, x[31]};
      if (wsel == W_12) begin
         f = y12[36:4];
      end else if (wsel == W_24) begin
         f = y24[48:16];
      end
      return f;
   endfunction

endpackage

// ----- rtl/psu_if.sv -----
`timescale 1ns / 1ps
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface psu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_code;
   logic [32:0] fraction;
   logic        last_of_byte;
   logic        last_of_set;

   modport source (output valid, output sample_code, output fraction,
                   output last_of_byte, output last_of_set, input ready);
   modport sink (input valid, input sample_code, input fraction,
                 input last_of_byte, input last_of_set, output ready);
endinterface

// ----- rtl/psu_front.sv -----
`timescale 1ns / 1ps
module psu_front
   import psu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   psu_req_if.sink     req,
   input  logic        pop,
   output byte_type    head
);

   logic [7:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, do_pop;

   assign req.ready  = (cnt_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign do_pop     = pop && (cnt_ff != 2'd0);
   assign head.valid = (cnt_ff != 2'd0);
   assign head.data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req.data_byte;
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff)) else $error("queue pointers");
   a_full_eq: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 || cnt_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers at full/empty");
`endif

endmodule

// ----- rtl/psu_engine.sv -----
`timescale 1ns / 1ps
module psu_engine
   import psu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  byte_type    head,
   output logic        pop,
   psu_rsp_if.source   rsp
);

   logic [BUF_WIDTH-1:0]   buf_ff, buf_in;
   logic [BITS_WIDTH-1:0]  held_ff, held_in;
   logic [COUNT_WIDTH-1:0] done_ff, done_in;

   logic                   valid_ff, valid_in;
   logic [CODE_WIDTH-1:0]  code_ff, code_in;
   logic [FRAC_WIDTH-1:0]  frac_ff, frac_in;
   logic                   lob_ff, lob_in;
   logic                   los_ff, los_in;

   logic [BITS_WIDTH-1:0]  bps, eff_held, rem;
   logic [BUF_WIDTH-1:0]   eff_buf;
   logic [COUNT_WIDTH-1:0] next_done;
   logic                   out_ready, need_byte, can_step, emit, set_end;
   logic [CODE_WIDTH-1:0]  code_mask;

   assign rsp.valid        = valid_ff;
   assign rsp.sample_code  = code_ff;
   assign rsp.fraction     = frac_ff;
   assign rsp.last_of_byte = lob_ff;
   assign rsp.last_of_set  = los_ff;

   always_comb begin
      bps       = sample_bits(cfg.wsel);
      out_ready = !valid_ff || rsp.ready;
      need_byte = (held_ff < bps);
      eff_buf   = need_byte ? {buf_ff[BUF_WIDTH-9:0], head.data} : buf_ff;
      eff_held  = need_byte ? held_ff + 6'd8 : held_ff;
      can_step  = out_ready && (!need_byte || head.valid);
      emit      = can_step && (eff_held >= bps);
      pop       = can_step && need_byte;
      rem       = eff_held - bps;
      code_mask = 32'hFFFF_FFFF >> (6'd32 - bps);
      code_in   = CODE_WIDTH'(eff_buf >> rem) & code_mask;
      frac_in   = norm_fraction(code_in, cfg.wsel);
      next_done = done_ff + COUNT_WIDTH'(1);
      set_end   = (next_done >= cfg.target) || (next_done == '0);
      lob_in    = set_end || (rem < bps);
      los_in    = set_end;

      buf_in  = buf_ff;
      held_in = held_ff;
      done_in = done_ff;
      if (cfg.clear || (emit && set_end)) begin
         buf_in  = '0;
         held_in = '0;
         done_in = '0;
      end else if (emit) begin
         buf_in  = eff_buf & ((BUF_WIDTH'(1) << rem) - BUF_WIDTH'(1));
         held_in = rem;
         done_in = next_done;
      end else if (can_step) begin
         buf_in  = eff_buf;
         held_in = eff_held;
      end

      valid_in = emit || (valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         held_ff  <= '0;
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         buf_ff   <= buf_in;
         held_ff  <= held_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         code_ff <= code_in;
         frac_ff <= frac_in;
         lob_ff  <= lob_in;
         los_ff  <= los_in;
      end
   end

`ifndef SYNTHESIS
   a_held_max: assert property (@(posedge clock) disable iff (reset)
      held_ff <= 6'(BUF_WIDTH)) else $error("bit count overflow");
   a_buf_clean: assert property (@(posedge clock) disable iff (reset)
      (buf_ff >> held_ff) == '0) else $error("stale bits above fill level");
   a_done_below: assert property (@(posedge clock) disable iff (reset)
      done_ff < cfg.target) else $error("sample counter passed set size");
   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (emit && set_end) |=> (held_ff == '0 && done_ff == '0))
      else $error("set end did not clear state");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp.ready) |-> !emit) else $error("result overwritten");
`endif

endmodule

// ----- rtl/packed_sample_unpacker.sv -----
`timescale 1ns / 1ps
// Bit-packed sample unpacker.
// req carries one source byte per item; rsp carries one sample per item:
// the raw code (MSB-first extraction), its Q1.32 normalized value, and
// flags for the last sample of a byte and the last sample of a set.
// csr is an APB-style port: 0x0 width_select (3 bits), 0x4 sample_count.
// A register write restarts the set; write only while the block is idle.
// Bytes go into a 2-entry queue; the extractor takes one step per cycle
// unless rsp stalls or it waits for a byte: it loads a byte and emits a
// sample together, loads a byte alone, or emits from bits already held.
// One sample leaves per cycle at most, and a byte yields 8/bits samples
// for widths under 8; the rate is set by the single extraction step per
// cycle. A completed sample is held in the output register until taken.
// Reset (synchronous) empties the queue, clears the bit buffer and counter
// and sets 8-bit samples, one per set. When rsp stalls the output register
// holds, the extractor waits, and req keeps taking bytes until the queue
// is full.
module packed_sample_unpacker
   import psu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   psu_req_if.sink               req_chan,
   psu_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [DATA_WIDTH-1:0] csr_pwdata,
   output logic [DATA_WIDTH-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [WSEL_WIDTH-1:0]  wsel_ff, wsel_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   wr_en;
   cfg_type                cfg;
   byte_type               head;
   logic                   pop;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wsel_in  = wsel_ff;
      count_in = count_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_WIDTH_SELECT: wsel_in  = csr_pwdata[WSEL_WIDTH-1:0];
            default:          count_in = csr_pwdata[COUNT_WIDTH-1:0];
         endcase
      end
      unique case (csr_paddr[2])
         REG_WIDTH_SELECT: csr_prdata = DATA_WIDTH'(wsel_ff);
         default:          csr_prdata = DATA_WIDTH'(count_ff);
      endcase
      cfg.clear  = wr_en;
      cfg.wsel   = wsel_ff;
      cfg.target = (count_ff == '0) ? COUNT_WIDTH'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsel_ff  <= WSEL_RESET;
         count_ff <= COUNT_RESET;
      end else begin
         wsel_ff  <= wsel_in;
         count_ff <= count_in;
      end
   end

   psu_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head)
   );

   psu_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
